// ===== hdl/cell_glyph_tile_renderer_defines.svh =====
// ----------------------------------------------------------------------------
// Cell glyph tile renderer: assertion macros
// Shared property forms for the renderer's embedded checks.
// ----------------------------------------------------------------------------
`ifndef CELL_GLYPH_TILE_RENDERER_DEFINES_SVH
`define CELL_GLYPH_TILE_RENDERER_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define CGTR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cgtr same-cycle check failed");

// Next-cycle implication, checked on every clock outside reset.
`define CGTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cgtr next-cycle check failed");

`endif

// ===== hdl/cgtr_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell glyph tile renderer package
// Payload types, register indexes, tile geometry and color constants.
// ----------------------------------------------------------------------------
package cgtr_pkg;

  typedef logic [2:0] tier_t;
  typedef logic [8:0] level_sum_t;

  typedef struct packed {
    logic [7:0] core_value;
    logic [7:0] link_value;
    logic [7:0] delta_value;
    logic [7:0] priority_value;
  } in_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [2:0] pixel_column;
    logic [2:0] pixel_row;
    logic       last_pixel;
  } out_t;

  typedef enum logic [2:0] {
    RegTileSize = 3'd0,
    RegCoreThr  = 3'd1,
    RegLinkThr  = 3'd2,
    RegDeltaThr = 3'd3,
    RegPrioThr  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    tier_t r;
    tier_t g;
    tier_t b;
    tier_t a;
  } tiers_t;

  // Per-size mask boundaries; the user must keep them fixed while a tile is out, the block does not enforce it.
  typedef struct packed {
    logic [2:0] last;
    logic [2:0] c0;
    logic [2:0] c1;
    logic [2:0] mlo;
    logic [2:0] mhi;
    logic [2:0] span_lo;
    logic [2:0] span_hi;
    logic       even;
  } geo_t;

  typedef struct packed {
    logic [2:0] x;
    logic [2:0] y;
    logic       last;
    in_t        src;
    tiers_t     tiers;
  } pix_t;

  typedef struct packed {
    logic [2:0] x;
    logic [2:0] y;
    logic       last;
    in_t        src;
    tiers_t     tiers;
    logic       centre;
    logic       cross_on;
    logic       corner;
    logic       border;
  } mask_t;

  typedef struct packed {
    logic [2:0] x;
    logic [2:0] y;
    logic       last;
    level_sum_t r;
    level_sum_t g;
    level_sum_t b;
  } sum_t;

  localparam logic [3:0]  MinTileSize   = 4'd2;
  localparam logic [3:0]  MaxTileSize   = 4'd8;
  localparam logic [3:0]  ResetTileSize = 4'd4;
  localparam logic [23:0] ResetThr      = 24'h602008;
  localparam tier_t       TierNone      = 3'd0;
  localparam tier_t       TierTop       = 3'd4;

  localparam level_sum_t CentreBase  = 9'd40;
  localparam level_sum_t CentreStep  = 9'd40;
  localparam level_sum_t CentreSide  = 9'd8;
  localparam level_sum_t CrossBase   = 9'd30;
  localparam level_sum_t CrossStep   = 9'd35;
  localparam level_sum_t CrossSide   = 9'd6;
  localparam level_sum_t CornerBase  = 9'd35;
  localparam level_sum_t CornerStep  = 9'd35;
  localparam level_sum_t CornerSide  = 9'd6;
  localparam level_sum_t BorderStep  = 9'd10;
  localparam level_sum_t CentreBleed = 9'd24;
  localparam level_sum_t CrossBleed  = 9'd20;
  localparam level_sum_t CornerBleed = 9'd20;
  localparam level_sum_t BorderBleed = 9'd10;
  localparam level_sum_t LevelMax    = 9'd255;

  function automatic tier_t tier_of(logic [7:0] v, logic [23:0] lim);
    tier_t t;
    if (v == 8'd0) begin
      t = TierNone;
    end else if (v <= lim[7:0]) begin
      t = 3'd1;
    end else if (v <= lim[15:8]) begin
      t = 3'd2;
    end else if (v <= lim[23:16]) begin
      t = 3'd3;
    end else begin
      t = TierTop;
    end
    return t;
  endfunction

  function automatic logic [3:0] clamp_size(logic [3:0] s);
    logic [3:0] r;
    if (s < MinTileSize) begin
      r = MinTileSize;
    end else if (s > MaxTileSize) begin
      r = MaxTileSize;
    end else begin
      r = s;
    end
    return r;
  endfunction

  // n / 3 for the legal sizes
  function automatic logic [3:0] third_of(logic [3:0] n);
    logic [3:0] r;
    unique case (n)
      4'd3, 4'd4, 4'd5: r = 4'd1;
      4'd6, 4'd7, 4'd8: r = 4'd2;
      default:          r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic geo_t tile_geom(logic [3:0] n);
    geo_t       g;
    logic [3:0] q;
    logic [3:0] h;
    logic [3:0] s;
    q         = n >> 2;
    h         = n >> 1;
    s         = third_of(n);
    g.last    = 3'(n - 4'd1);
    g.c0      = q[2:0];
    g.c1      = 3'(n - q);
    g.mlo     = 3'(h - 4'd1);
    g.mhi     = h[2:0];
    g.span_lo = s[2:0];
    g.span_hi = 3'(n - s);
    g.even    = ~n[0];
    return g;
  endfunction

endpackage

// ===== hdl/cell_glyph_tile_renderer.sv =====
// ----------------------------------------------------------------------------
// Cell glyph tile renderer
// Turns one four-byte cell into a square tile of clamped RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one cell per item (core, link, delta, priority bytes).
//   out channel : one pixel per item, raster order, last_pixel on the final
//                 pixel of the tile.
//   cfg channel : index/data writes, always ready; write only while idle.
// Throughput: a cell produces N*N pixels (N = tile_size, 2..8, 4 at reset,
//   so 16 pixels) and the pixel counter issues one pixel per cycle while
//   the output is not stalled. The next cell is taken in the cycle that issues
//   the last pixel of the current one, so tiles follow each other with no gap.
// Pipeline: from cell accept to the output a pixel passes the counter,
//   coordinate, mask, sum and clamp stages in that order.
// Reset: pipeline empties, tile_size returns to 4 and every threshold
//   register to 8/32/96.
// Stall: when the receiver holds ready low on a valid output item the pipeline
//   freezes; no pixel is dropped or repeated and the output item holds.
// ----------------------------------------------------------------------------
`include "cell_glyph_tile_renderer_defines.svh"

module cell_glyph_tile_renderer
  import cgtr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  // Configuration
  geo_t        geo_q;
  logic [23:0] thr_q [4];

  // Pixel counter stage
  logic        busy_q;
  logic [2:0]  x_q, y_q;
  in_t         cell_q;
  tiers_t      tiers_q;

  // Pipeline stages
  logic        p1_valid_q, p2_valid_q, p3_valid_q, out_valid_q;
  pix_t        p1_q;
  mask_t       p2_q, p2_d;
  sum_t        p3_q, p3_d;
  out_t        out_q, out_d;

  logic        adv;
  logic        gen_last;
  logic        in_take;

  assign cfg_ready_o = 1'b1;
  assign adv         = !out_valid_q || out_ready_i;
  assign gen_last    = (x_q == geo_q.last) && (y_q == geo_q.last);
  assign in_ready_o  = !busy_q || (adv && gen_last);
  assign in_take     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_q <= tile_geom(ResetTileSize);
      for (int i = 0; i < 4; i++) begin
        thr_q[i] <= ResetThr;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        RegTileSize: geo_q    <= tile_geom(clamp_size(cfg_data_i[3:0]));
        RegCoreThr:  thr_q[0] <= cfg_data_i;
        RegLinkThr:  thr_q[1] <= cfg_data_i;
        RegDeltaThr: thr_q[2] <= cfg_data_i;
        RegPrioThr:  thr_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Counter control and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      x_q         <= 3'd0;
      y_q         <= 3'd0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        busy_q <= 1'b1;
        x_q    <= 3'd0;
        y_q    <= 3'd0;
      end else if (busy_q && adv) begin
        if (gen_last) begin
          busy_q <= 1'b0;
          x_q    <= 3'd0;
          y_q    <= 3'd0;
        end else if (x_q == geo_q.last) begin
          x_q <= 3'd0;
          y_q <= y_q + 3'd1;
        end else begin
          x_q <= x_q + 3'd1;
        end
      end
      if (adv) begin
        p1_valid_q  <= busy_q;
        p2_valid_q  <= p1_valid_q;
        p3_valid_q  <= p2_valid_q;
        out_valid_q <= p3_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cell_q    <= in_data_i;
      tiers_q.r <= tier_of(in_data_i.core_value, thr_q[0]);
      tiers_q.g <= tier_of(in_data_i.link_value, thr_q[1]);
      tiers_q.b <= tier_of(in_data_i.delta_value, thr_q[2]);
      tiers_q.a <= tier_of(in_data_i.priority_value, thr_q[3]);
    end
    if (adv) begin
      p1_q.x     <= x_q;
      p1_q.y     <= y_q;
      p1_q.last  <= gen_last;
      p1_q.src   <= cell_q;
      p1_q.tiers <= tiers_q;
      p2_q       <= p2_d;
      p3_q       <= p3_d;
      out_q      <= out_d;
    end
  end

  // Mask stage
  always_comb begin
    logic xl, xh, yl, yh;
    p2_d.x        = p1_q.x;
    p2_d.y        = p1_q.y;
    p2_d.last     = p1_q.last;
    p2_d.src      = p1_q.src;
    p2_d.tiers    = p1_q.tiers;
    p2_d.centre   = (p1_q.x >= geo_q.c0) && (p1_q.x < geo_q.c1) &&
                    (p1_q.y >= geo_q.c0) && (p1_q.y < geo_q.c1);
    p2_d.cross_on = (p1_q.x == geo_q.mhi) || (p1_q.y == geo_q.mhi) ||
                    (geo_q.even && ((p1_q.x == geo_q.mlo) || (p1_q.y == geo_q.mlo)));
    xl            = p1_q.x < geo_q.span_lo;
    xh            = p1_q.x >= geo_q.span_hi;
    yl            = p1_q.y < geo_q.span_lo;
    yh            = p1_q.y >= geo_q.span_hi;
    p2_d.corner   = (xl || xh) && (yl || yh);
    p2_d.border   = (p1_q.x == 3'd0) || (p1_q.y == 3'd0) ||
                    (p1_q.x == geo_q.last) || (p1_q.y == geo_q.last);
  end

  // Sum stage
  always_comb begin
    level_sum_t rt, gt, bt, at, glow;
    logic       on_r, on_g, on_b, on_a;
    rt   = 9'(p2_q.tiers.r);
    gt   = 9'(p2_q.tiers.g);
    bt   = 9'(p2_q.tiers.b);
    at   = 9'(p2_q.tiers.a);
    glow = 9'(p2_q.src.priority_value[7:5]);
    on_r = (p2_q.tiers.r != TierNone) && p2_q.centre;
    on_g = (p2_q.tiers.g != TierNone) && p2_q.cross_on;
    on_b = (p2_q.tiers.b != TierNone) && p2_q.corner;
    on_a = (p2_q.tiers.a != TierNone) && p2_q.border;

    p3_d.x    = p2_q.x;
    p3_d.y    = p2_q.y;
    p3_d.last = p2_q.last;
    p3_d.r    = 9'(p2_q.src.core_value[7:4]) + glow;
    p3_d.g    = 9'(p2_q.src.link_value[7:4]) + glow;
    p3_d.b    = 9'(p2_q.src.delta_value[7:4]) + glow;
    if (on_r) begin
      p3_d.r = p3_d.r + CentreBase + 9'(rt * CentreStep);
      p3_d.g = p3_d.g + 9'(rt * CentreSide);
      p3_d.b = p3_d.b + 9'(rt * CentreSide);
    end
    if (on_g) begin
      p3_d.g = p3_d.g + CrossBase + 9'(gt * CrossStep);
      p3_d.r = p3_d.r + 9'(gt * CrossSide);
      p3_d.b = p3_d.b + 9'(gt * CrossSide);
    end
    if (on_b) begin
      p3_d.b = p3_d.b + CornerBase + 9'(bt * CornerStep);
      p3_d.r = p3_d.r + 9'(bt * CornerSide);
      p3_d.g = p3_d.g + 9'(bt * CornerSide);
    end
    if (on_a) begin
      p3_d.r = p3_d.r + 9'(at * BorderStep);
      p3_d.g = p3_d.g + 9'(at * BorderStep);
      p3_d.b = p3_d.b + 9'(at * BorderStep);
    end
    // top tier bleeds outside its own mask
    if ((p2_q.tiers.r == TierTop) && !p2_q.centre)   p3_d.r = p3_d.r + CentreBleed;
    if ((p2_q.tiers.g == TierTop) && !p2_q.cross_on) p3_d.g = p3_d.g + CrossBleed;
    if ((p2_q.tiers.b == TierTop) && !p2_q.corner)   p3_d.b = p3_d.b + CornerBleed;
    if ((p2_q.tiers.a == TierTop) && !p2_q.border) begin
      p3_d.r = p3_d.r + BorderBleed;
      p3_d.g = p3_d.g + BorderBleed;
      p3_d.b = p3_d.b + BorderBleed;
    end
  end

  // Clamp stage
  always_comb begin
    out_d.red_level    = (p3_q.r > LevelMax) ? 8'hFF : p3_q.r[7:0];
    out_d.green_level  = (p3_q.g > LevelMax) ? 8'hFF : p3_q.g[7:0];
    out_d.blue_level   = (p3_q.b > LevelMax) ? 8'hFF : p3_q.b[7:0];
    out_d.pixel_column = p3_q.x;
    out_d.pixel_row    = p3_q.y;
    out_d.last_pixel   = p3_q.last;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CGTR_ASSERT_SAME(a_last_on_diagonal, out_valid_o && out_data_o.last_pixel,
                    out_data_o.pixel_column == out_data_o.pixel_row)
  `CGTR_ASSERT_SAME(a_pixel_in_tile, out_valid_o,
                    (out_data_o.pixel_column <= geo_q.last) &&
                    (out_data_o.pixel_row <= geo_q.last))
  `CGTR_ASSERT_NEXT(a_stall_holds_counter, busy_q && !adv && !in_take,
                    $stable(x_q) && $stable(y_q) && busy_q)
  `CGTR_ASSERT_NEXT(a_stall_keeps_pixels, p1_valid_q && !adv, p1_valid_q)

endmodule
